// ===== rtl/wsgd_pkg.sv =====
// Package with the beat types, command codes, register indexes and state types of the detector.
package wsgd_pkg;

	typedef enum logic [1:0] {
		CMD_SAMPLE     = 2'd0,
		CMD_REFRESH    = 2'd1,
		CMD_RESET_BASE = 2'd2,
		CMD_UNUSED     = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_MIN_SAMPLES          = 3'd0,
		REG_PROCESS_GROWTH_LIMIT = 3'd1,
		REG_PROCESS_SLOPE_LIMIT  = 3'd2,
		REG_TRACKED_GROWTH_LIMIT = 3'd3,
		REG_TRACKED_SLOPE_LIMIT  = 3'd4,
		REG_OBJECT_GROWTH_LIMIT  = 3'd5,
		REG_SPARE6               = 3'd6,
		REG_SPARE7               = 3'd7
	} reg_index_t;

	localparam int YW = 36;
	localparam int CFG_W = 48;
	localparam logic [47:0] SLOPE_MAX = 48'h7FFF_FFFF_FFFF;

	typedef struct packed {
		logic [1:0]  command;
		logic        process_available;
		logic [47:0] private_bytes;
		logic [47:0] tracked_bytes;
		logic [31:0] tracked_count;
	} in_beat_t;

	typedef struct packed {
		logic signed [47:0] process_slope;
		logic signed [47:0] tracked_slope;
		logic [47:0]        process_growth;
		logic [47:0]        tracked_growth;
		logic [31:0]        object_growth;
		logic [7:0]         process_samples;
		logic               enough_samples;
		logic               process_growing;
		logic               resources_growing;
	} out_beat_t;

	typedef enum logic [2:0] {
		SL_IDLE, SL_WALK, SL_MUL, SL_SUB, SL_PREP, SL_DIV, SL_ROUND, SL_DONE
	} slp_state_t;

	typedef enum logic [2:0] {
		TS_IDLE, TS_PSTART, TS_PWAIT, TS_TSTART, TS_TWAIT, TS_OUT
	} top_state_t;

endpackage

// ===== rtl/windowed_slope_growth_detector.sv =====
// Top level of the windowed slope growth detector: state, baselines, sequencer and result register.
//
//   channel   direction  handshake            payload
//   in        to block   in_valid/in_ready    in_data (in_beat_t)
//   out       from block out_valid/out_ready  out_data (out_beat_t)
//   cfg       to block   cfg_we               cfg_index, cfg_data
//
// Each beat runs the slope engine over the process history and then over the tracked history
// before the next ready; the window of a history is its fill capped at SLOPE_WINDOW. The engine
// walks the window through the registered read port, forms the sums, runs the bit-serial divider
// and rounds; a history under three entries skips all of these steps.
// Reset clears all control state, fills, heads, current values and baselines at once.
// A finished result waits in the output register; a new beat is taken meanwhile, and
// the block holds its next result back until that register is free.
module windowed_slope_growth_detector #(
	parameter int SLOPE_WINDOW  = 60,
	parameter int HISTORY_LIMIT = 240
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  wsgd_pkg::in_beat_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output wsgd_pkg::out_beat_t  out_data,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [47:0]          cfg_data
);
	import wsgd_pkg::*;

	localparam int HW = (SLOPE_WINDOW > 1) ? $clog2(SLOPE_WINDOW) : 1;
	localparam int NW = $clog2(SLOPE_WINDOW + 1);
	localparam int FW = $clog2(HISTORY_LIMIT + 1);
	localparam int MW = ((FW > NW) ? FW : NW) + 1;

	top_state_t state_q, state_d;

	logic [7:0]  min_samples_q;
	logic [47:0] pg_limit_q, tg_limit_q;
	logic [23:0] ps_limit_q, ts_limit_q;
	logic [31:0] og_limit_q;

	logic [FW-1:0] pfill_q, tfill_q;
	logic [HW-1:0] phead_q, thead_q;
	logic [47:0]   cur_pb_q, cur_tb_q, base_pb_q, base_tb_q;
	logic [31:0]   cur_tc_q, base_tc_q;
	logic          cur_avail_q, base_cap_q;

	logic [47:0] pg_q, tg_q, ps_q;
	logic [31:0] og_q;
	logic        out_valid_q;
	out_beat_t   out_q;

	logic          accept, start, sel_proc, sdone, enough;
	logic          pw_we, tw_we;
	logic [HW-1:0] raddr, s_head;
	logic [YW-1:0] p_rdata, t_rdata;
	logic [NW-1:0] s_n;
	logic [MW-1:0] fill_ext;
	logic [47:0]   s_slope;
	logic [FW+7:0] samples_ext;
	logic          ps_above, ts_above;
	cmd_t          cmd;

	assign cmd    = cmd_t'(in_data.command);
	assign accept = in_valid && in_ready;
	assign pw_we  = accept && cmd == CMD_SAMPLE && in_data.process_available;
	assign tw_we  = accept && cmd == CMD_SAMPLE;

	always_comb begin
		state_d = state_q;
		case (state_q)
			TS_IDLE:   if (accept) state_d = TS_PSTART;
			TS_PSTART: state_d = TS_PWAIT;
			TS_PWAIT:  if (sdone) state_d = TS_TSTART;
			TS_TSTART: state_d = TS_TWAIT;
			TS_TWAIT:  if (sdone) state_d = TS_OUT;
			TS_OUT:    if (!out_valid_q || out_ready) state_d = TS_IDLE;
			default:   state_d = TS_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == TS_IDLE);
		start    = (state_q == TS_PSTART) || (state_q == TS_TSTART);
		sel_proc = (state_q == TS_PSTART) || (state_q == TS_PWAIT);
	end

	assign fill_ext = sel_proc ? MW'(pfill_q) : MW'(tfill_q);
	assign s_n      = (fill_ext >= MW'(SLOPE_WINDOW)) ? NW'(SLOPE_WINDOW) : NW'(fill_ext);
	assign s_head   = sel_proc ? phead_q : thead_q;

	wsgd_ring #(.DEPTH(SLOPE_WINDOW)) u_pring (
		.clk(clk), .we(pw_we), .waddr(phead_q), .wdata(in_data.private_bytes[47:12]),
		.raddr(raddr), .rdata(p_rdata)
	);

	wsgd_ring #(.DEPTH(SLOPE_WINDOW)) u_tring (
		.clk(clk), .we(tw_we), .waddr(thead_q), .wdata(in_data.tracked_bytes[47:12]),
		.raddr(raddr), .rdata(t_rdata)
	);

	wsgd_slope #(.WIN(SLOPE_WINDOW)) u_slope (
		.clk(clk), .arst_n(arst_n), .start(start), .head(s_head), .n(s_n),
		.rd_addr(raddr), .rd_data(sel_proc ? p_rdata : t_rdata),
		.done(sdone), .slope(s_slope)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= TS_IDLE;
			min_samples_q <= 8'd30;
			pg_limit_q    <= 48'd16777216;
			ps_limit_q    <= 24'd512;
			tg_limit_q    <= 48'd8388608;
			ts_limit_q    <= 24'd256;
			og_limit_q    <= 32'd16;
			pfill_q       <= '0;
			tfill_q       <= '0;
			phead_q       <= '0;
			thead_q       <= '0;
			cur_pb_q      <= '0;
			cur_tb_q      <= '0;
			cur_tc_q      <= '0;
			cur_avail_q   <= 1'b0;
			base_pb_q     <= '0;
			base_tb_q     <= '0;
			base_tc_q     <= '0;
			base_cap_q    <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (reg_index_t'(cfg_index))
					REG_MIN_SAMPLES:          min_samples_q <= cfg_data[7:0];
					REG_PROCESS_GROWTH_LIMIT: pg_limit_q    <= cfg_data;
					REG_PROCESS_SLOPE_LIMIT:  ps_limit_q    <= cfg_data[23:0];
					REG_TRACKED_GROWTH_LIMIT: tg_limit_q    <= cfg_data;
					REG_TRACKED_SLOPE_LIMIT:  ts_limit_q    <= cfg_data[23:0];
					REG_OBJECT_GROWTH_LIMIT:  og_limit_q    <= cfg_data[31:0];
					default: begin
					end
				endcase
			end
			if (accept) begin
				case (cmd)
					CMD_SAMPLE: begin
						cur_avail_q <= in_data.process_available;
						cur_pb_q    <= in_data.process_available ? in_data.private_bytes : '0;
						cur_tb_q    <= in_data.tracked_bytes;
						cur_tc_q    <= in_data.tracked_count;
						if (in_data.process_available) begin
							phead_q <= (phead_q == HW'(SLOPE_WINDOW - 1)) ? '0 : phead_q + 1'b1;
							if (pfill_q < FW'(HISTORY_LIMIT)) pfill_q <= pfill_q + 1'b1;
						end
						thead_q <= (thead_q == HW'(SLOPE_WINDOW - 1)) ? '0 : thead_q + 1'b1;
						if (tfill_q < FW'(HISTORY_LIMIT)) tfill_q <= tfill_q + 1'b1;
						if (!base_cap_q && in_data.process_available) begin
							base_pb_q  <= in_data.private_bytes;
							base_tb_q  <= in_data.tracked_bytes;
							base_tc_q  <= in_data.tracked_count;
							base_cap_q <= 1'b1;
						end
					end
					CMD_REFRESH: begin
						cur_tb_q <= in_data.tracked_bytes;
						cur_tc_q <= in_data.tracked_count;
					end
					CMD_RESET_BASE: begin
						base_pb_q  <= cur_pb_q;
						base_tb_q  <= cur_tb_q;
						base_tc_q  <= cur_tc_q;
						base_cap_q <= cur_avail_q;
						pfill_q    <= '0;
						tfill_q    <= '0;
						phead_q    <= '0;
						thead_q    <= '0;
					end
					default: begin
					end
				endcase
			end
			if (state_q == TS_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign samples_ext = (FW+8)'(pfill_q);
	assign enough      = samples_ext >= (FW+8)'(min_samples_q);
	assign ps_above    = !ps_q[47] && (ps_q[46:0] > 47'(ps_limit_q));
	assign ts_above    = !s_slope[47] && (s_slope[46:0] > 47'(ts_limit_q));

	always_ff @(posedge clk) begin
		if (state_q == TS_PSTART) begin
			pg_q <= (cur_pb_q > base_pb_q) ? cur_pb_q - base_pb_q : '0;
			tg_q <= (cur_tb_q > base_tb_q) ? cur_tb_q - base_tb_q : '0;
			og_q <= (cur_tc_q > base_tc_q) ? cur_tc_q - base_tc_q : '0;
		end
		if (state_q == TS_PWAIT && sdone) begin
			ps_q <= s_slope;
		end
		if (state_q == TS_OUT && (!out_valid_q || out_ready)) begin
			out_q.process_slope     <= ps_q;
			out_q.tracked_slope     <= s_slope;
			out_q.process_growth    <= pg_q;
			out_q.tracked_growth    <= tg_q;
			out_q.object_growth     <= og_q;
			out_q.process_samples   <= samples_ext[7:0];
			out_q.enough_samples    <= enough;
			out_q.process_growing   <= enough && (pg_q > pg_limit_q) && ps_above;
			out_q.resources_growing <= enough &&
				(((tg_q > tg_limit_q) && ts_above) || (og_q > og_limit_q));
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule

// ===== rtl/wsgd_ring.sv =====
// Sample history ring memory with one write port and one registered read port.
module wsgd_ring #(
	parameter int DEPTH = 60
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [wsgd_pkg::YW-1:0]               wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [wsgd_pkg::YW-1:0]               rdata
);
	import wsgd_pkg::*;

	logic [YW-1:0] mem [DEPTH];
	logic [YW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== rtl/wsgd_slope.sv =====
// Least-squares slope engine: walks a history, forms the sums and divides one bit per cycle.
module wsgd_slope #(
	parameter int WIN = 60
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [(WIN > 1 ? $clog2(WIN) : 1)-1:0] head,
	input  logic [$clog2(WIN+1)-1:0]            n,
	output logic [(WIN > 1 ? $clog2(WIN) : 1)-1:0] rd_addr,
	input  logic [wsgd_pkg::YW-1:0]             rd_data,
	output logic                                done,
	output logic [47:0]                         slope
);
	import wsgd_pkg::*;

	localparam int HW   = (WIN > 1) ? $clog2(WIN) : 1;
	localparam int NW   = $clog2(WIN + 1);
	localparam int SXW  = 2 * NW;
	localparam int SXXW = 3 * NW;
	localparam int SYW  = YW + NW;
	localparam int SXYW = YW + 2 * NW;
	localparam int AW   = YW + 3 * NW;
	localparam int DW   = 4 * NW;
	localparam int DVW  = AW + 7;
	localparam int CW   = $clog2(DVW + 1);

	slp_state_t state_q, state_d;

	logic [NW-1:0]   n_q, idx_q, xd_q;
	logic [HW-1:0]   addr_q;
	logic            dv_q;
	logic [SXW-1:0]  sx_q;
	logic [SXXW-1:0] sxx_q;
	logic [SYW-1:0]  sy_q;
	logic [SXYW-1:0] sxy_q;
	logic [AW-1:0]   a_q, b_q, mag_q;
	logic [DW-1:0]   p1_q, p2_q, den_q;
	logic            neg_q;
	logic [DW-1:0]   rem_q;
	logic [DVW-1:0]  quo_q;
	logic [CW-1:0]   cnt_q;
	logic [47:0]     slope_q;

	logic [NW:0]       hs, nn, start_ext;
	logic [2*NW-1:0]   xx;
	logic [YW+NW-1:0]  xy;
	logic [DW:0]       trial;
	logic              trial_ok;
	logic              up;
	logic [DVW:0]      res;
	logic [47:0]       mag48;
	logic              issue;

	assign hs        = (NW+1)'(head);
	assign nn        = (NW+1)'(n);
	assign start_ext = (hs >= nn) ? (hs - nn) : (hs + (NW+1)'(WIN) - nn);
	assign issue     = (state_q == SL_WALK) && (idx_q < n_q);
	assign xx        = (2*NW)'(xd_q) * (2*NW)'(xd_q);
	assign xy        = (YW+NW)'(xd_q) * (YW+NW)'(rd_data);
	assign trial     = {rem_q, quo_q[DVW-1]};
	assign trial_ok  = trial >= {1'b0, den_q};
	assign up        = {rem_q, 1'b0} >= {1'b0, den_q};
	assign res       = (DVW+1)'(quo_q) + (DVW+1)'(up);
	assign mag48     = (res > (DVW+1)'(SLOPE_MAX)) ? SLOPE_MAX : res[47:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			SL_IDLE:  if (start) state_d = (n < NW'(3)) ? SL_DONE : SL_WALK;
			SL_WALK:  if (idx_q == n_q && !dv_q) state_d = SL_MUL;
			SL_MUL:   state_d = SL_SUB;
			SL_SUB:   state_d = SL_PREP;
			SL_PREP:  state_d = (den_q == '0) ? SL_DONE : SL_DIV;
			SL_DIV:   if (cnt_q == CW'(DVW - 1)) state_d = SL_ROUND;
			SL_ROUND: state_d = SL_DONE;
			SL_DONE:  state_d = SL_IDLE;
			default:  state_d = SL_IDLE;
		endcase
	end

	always_comb begin
		done    = (state_q == SL_DONE);
		rd_addr = addr_q;
		slope   = slope_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SL_IDLE;
			dv_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			dv_q    <= issue;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SL_IDLE: begin
				n_q    <= n;
				idx_q  <= '0;
				addr_q <= HW'(start_ext);
				sx_q   <= '0;
				sxx_q  <= '0;
				sy_q   <= '0;
				sxy_q  <= '0;
				if (start && n < NW'(3)) begin
					slope_q <= '0;
				end
			end
			SL_WALK: begin
				if (issue) begin
					idx_q  <= idx_q + 1'b1;
					addr_q <= (addr_q == HW'(WIN - 1)) ? '0 : addr_q + 1'b1;
				end
				xd_q <= idx_q;
				if (dv_q) begin
					sx_q  <= sx_q + SXW'(xd_q);
					sxx_q <= sxx_q + SXXW'(xx);
					sy_q  <= sy_q + SYW'(rd_data);
					sxy_q <= sxy_q + SXYW'(xy);
				end
			end
			SL_MUL: begin
				a_q  <= AW'(AW'(n_q) * AW'(sxy_q));
				b_q  <= AW'(AW'(sx_q) * AW'(sy_q));
				p1_q <= DW'(DW'(n_q) * DW'(sxx_q));
				p2_q <= DW'(DW'(sx_q) * DW'(sx_q));
			end
			SL_SUB: begin
				den_q <= p1_q - p2_q;
				neg_q <= a_q < b_q;
				mag_q <= (a_q < b_q) ? (b_q - a_q) : (a_q - b_q);
			end
			SL_PREP: begin
				quo_q <= (DVW'(mag_q) << 7) - (DVW'(mag_q) << 3);
				rem_q <= '0;
				cnt_q <= '0;
				if (den_q == '0) begin
					slope_q <= '0;
				end
			end
			SL_DIV: begin
				rem_q <= trial_ok ? DW'(trial - {1'b0, den_q}) : DW'(trial);
				quo_q <= {quo_q[DVW-2:0], trial_ok};
				cnt_q <= cnt_q + 1'b1;
			end
			SL_ROUND: begin
				slope_q <= neg_q ? (48'd0 - mag48) : mag48;
			end
			default: begin
			end
		endcase
	end
endmodule
